// ===== hw/rtl/wfpd_pkg.sv =====
// Shared types and constants of the wall-following PD steering unit.
// Used by the configuration registers, the datapath core and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wfpd_pkg;

  // Field widths
  localparam int DIST_W   = 16;  // raw range reading, signed
  localparam int TGT_W    = 10;  // desired wall gap
  localparam int GAIN_W   = 16;  // kp_gain, unsigned Q8.8
  localparam int PWM_W    = 10;  // max_pwm
  localparam int SPEED_W  = 10;  // base_speed
  localparam int DRIVE_W  = 11;  // drive outputs, signed
  localparam int ERR_W    = 12;  // stored wall error, signed
  localparam int NEAR_W   = 9;   // a near reading lies in 1..349
  localparam int CORR_W   = 29;  // Q8.8 correction, signed
  localparam int DSUM_W   = 13;  // drive before the magnitude clamp, signed
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Constants of the control law
  localparam int MAX_VALID_DIST = 900;
  localparam int TRACK_LIMIT    = 350;
  localparam int KD_Q8          = 6400;  // derivative gain 25 in Q8.8
  localparam int DRIFT          = 60;

  // Register reset values
  localparam logic [TGT_W-1:0]  GAP_SETPOINT_RST = TGT_W'(150);
  localparam logic [GAIN_W-1:0] KP_GAIN_RST      = GAIN_W'(256);
  localparam logic [PWM_W-1:0]  MAX_PWM_RST      = PWM_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_SETPOINT = 2'd0,
    REG_KP_GAIN      = 2'd1,
    REG_MAX_PWM      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_EITHER = 2'd2,
    MODE_RIGHT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [TGT_W-1:0]  gap_setpoint;
    logic [GAIN_W-1:0] kp_gain;
    logic [PWM_W-1:0]  max_pwm;
  } cfg_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic                      drive_valid;
    logic                      tracking;
  } result_t;

  typedef struct packed {
    logic                    load;
    logic signed [ERR_W-1:0] value;
  } err_upd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wall_follow_pd_steer_unit.sv =====
// Top level of the wall-following PD steering unit: input stage, stored error,
// result register and configuration port. Depends on wfpd_pkg, wfpd_cfg_regs
// and wfpd_core.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   s_*     | in  | s_tvalid/s_tready  | tdata: dist_left, dist_right, base_speed
//           |     |                    | tuser: mode
//   m_*     | out | m_tvalid/m_tready  | tdata: drive_left, drive_right
//           |     |                    | tuser: drive_valid, tracking
//   cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready keeps the result register draining;
// the accepting edge loads the input register, and the PD result moves into the
// result register once that register is empty or being drained.
// The stored wall error is updated as an item leaves the input register, so the
// next item already sees it.
// Synchronous active-high reset clears both stage valids, the stored error and
// the registers to their defaults. cfg_ready is always high.
// A stalled result holds in the result register while one more beat is taken
// into the input register; s_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module wall_follow_pd_steer_unit
  import wfpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,   // [15:0] dist_left, [31:16] dist_right,
                                                // [41:32] base_speed, [47:42] zero
  input  wire logic [1:0]            s_tuser,   // [1:0] mode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [23:0]                m_tdata,   // [10:0] drive_left, [21:11] drive_right,
                                                // [23:22] zero
  output logic [1:0]                 m_tuser,   // [0] drive_valid, [1] tracking
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                      cfg;
  result_t                   res;
  err_upd_t                  err_upd;

  // Input stage
  logic                      in_valid;
  logic signed [DIST_W-1:0]  in_dl, in_dr;
  logic [1:0]                in_mode;
  logic [SPEED_W-1:0]        in_base;

  // Stored error of the last tracked tick (cleared when either-mode finds no near wall)
  logic signed [ERR_W-1:0]   prev_err;

  // Result register
  result_t                   out_res;

  logic                      out_load, in_adv, s_accept;

  assign cfg_ready = 1'b1;

  wfpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wfpd_core u_core (
    .dist_left  (in_dl),
    .dist_right (in_dr),
    .mode       (in_mode),
    .base_speed (in_base),
    .cfg        (cfg),
    .prev_err   (prev_err),
    .res        (res),
    .err_upd    (err_upd)
  );

  // Result register takes a new beat when empty or being drained.
  assign out_load = !m_tvalid || m_tready;
  assign in_adv   = in_valid && out_load;
  assign s_tready = !in_valid || out_load;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_accept) begin
      in_dl   <= s_tdata[15:0];
      in_dr   <= s_tdata[31:16];
      in_base <= s_tdata[41:32];
      in_mode <= s_tuser;
    end
  end

  // Advance the stored error only as its item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (in_adv && err_upd.load) begin
      prev_err <= err_upd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
    if (in_adv) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.drive_right, out_res.drive_left};
  assign m_tuser = {out_res.tracking, out_res.drive_valid};

  // Tracking is only ever reported together with a drive command.
  a_track_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.tracking |-> out_res.drive_valid)
    else $error("tracking without drive command");

  // No command means zero drive fields.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.drive_valid |->
      (out_res.drive_left == '0) && (out_res.drive_right == '0))
    else $error("nonzero drive without command");

  // Drive magnitude stays within max_pwm.
  a_drive_lim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (out_res.drive_left  <=  $signed({1'b0, cfg.max_pwm})) &&
      (out_res.drive_left  >= -$signed({1'b0, cfg.max_pwm})) &&
      (out_res.drive_right <=  $signed({1'b0, cfg.max_pwm})) &&
      (out_res.drive_right >= -$signed({1'b0, cfg.max_pwm})))
    else $error("drive exceeds max_pwm");

  // The stored error moves only when an item leaves the input stage.
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    !in_adv |=> $stable(prev_err))
    else $error("stored error changed without an item");

  // Stored error stays within the range the error can take.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    (prev_err >= -ERR_W'(TRACK_LIMIT)) && (prev_err <= ERR_W'(1023)))
    else $error("stored error out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/wfpd_cfg_regs.sv =====
// Configuration register file of the wall-following PD steering unit.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfpd_cfg_regs
  import wfpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_setpoint <= GAP_SETPOINT_RST;
      cfg.kp_gain      <= KP_GAIN_RST;
      cfg.max_pwm      <= MAX_PWM_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAP_SETPOINT: cfg.gap_setpoint <= wr_data[TGT_W-1:0];
        REG_KP_GAIN:      cfg.kp_gain      <= wr_data[GAIN_W-1:0];
        REG_MAX_PWM:      cfg.max_pwm      <= wr_data[PWM_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wfpd_core.sv =====
// Combinational PD steering datapath: wall selection, correction, drive clamp.
// Depends on wfpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfpd_core
  import wfpd_pkg::*;
(
  input  wire logic signed [DIST_W-1:0] dist_left,
  input  wire logic signed [DIST_W-1:0] dist_right,
  input  wire logic [1:0]               mode,
  input  wire logic [SPEED_W-1:0]       base_speed,
  input  wire cfg_t                     cfg,
  input  wire logic signed [ERR_W-1:0]  prev_err,
  output result_t                       res,
  output err_upd_t                      err_upd
);

  logic                       near_l, near_r;
  logic                       trk, trk_right, lost_drift, drift_right, clr;
  logic [NEAR_W-1:0]          dist_sel;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W:0]      diff;
  logic signed [CORR_W-1:0]   p_term, d_term, corr, half, corr_c, bq, sum_p, sum_n;
  logic signed [DSUM_W-1:0]   drv_p, drv_n, base_s, drift_s, raw_l, raw_r, lim;

  function automatic logic signed [DRIVE_W-1:0] clamp_drv(
    input logic signed [DSUM_W-1:0] v,
    input logic signed [DSUM_W-1:0] l
  );
    logic signed [DSUM_W-1:0] r;
    r = v;
    if (v > l) r = l;
    else if (v < -l) r = -l;
    return r[DRIVE_W-1:0];
  endfunction

  // A reading is near only if it lies in 1..349, above zero and below the track limit;
  // zero, negative and larger readings are never near.
  assign near_l = (dist_left > 0)  && (dist_left < DIST_W'(TRACK_LIMIT));
  assign near_r = (dist_right > 0) && (dist_right < DIST_W'(TRACK_LIMIT));

  always_comb begin
    trk         = 1'b0;
    trk_right   = 1'b0;
    lost_drift  = 1'b0;
    drift_right = 1'b0;
    clr         = 1'b0;
    case (mode_t'(mode))
      MODE_LEFT: begin
        if (near_l) trk = 1'b1;
        else        lost_drift = 1'b1;
      end
      MODE_EITHER: begin
        if (near_l) trk = 1'b1;
        else if (near_r) begin
          trk       = 1'b1;
          trk_right = 1'b1;
        end else clr = 1'b1;
      end
      MODE_RIGHT: begin
        if (near_r) begin
          trk       = 1'b1;
          trk_right = 1'b1;
        end else begin
          lost_drift  = 1'b1;
          drift_right = 1'b1;
        end
      end
      default: ;  // idle
    endcase
  end

  assign dist_sel = trk_right ? dist_right[NEAR_W-1:0] : dist_left[NEAR_W-1:0];

  assign err  = $signed({2'b00, cfg.gap_setpoint}) -
                $signed({{(ERR_W-NEAR_W){1'b0}}, dist_sel});
  assign diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err);

  assign p_term = CORR_W'($signed({1'b0, cfg.kp_gain})) * CORR_W'(err);
  assign d_term = CORR_W'(diff) * CORR_W'(KD_Q8);
  assign corr   = p_term + d_term;

  // Bound the correction to half the base speed (Q8.8).
  assign half = CORR_W'($signed({1'b0, base_speed, 7'd0}));
  always_comb begin
    corr_c = corr;
    if (corr > half) corr_c = half;
    else if (corr < -half) corr_c = -half;
  end

  // base +/- correction never goes negative, so the shift truncates toward zero.
  assign bq    = CORR_W'($signed({1'b0, base_speed, 8'd0}));
  assign sum_p = bq + corr_c;
  assign sum_n = bq - corr_c;
  assign drv_p = DSUM_W'(sum_p >>> 8);
  assign drv_n = DSUM_W'(sum_n >>> 8);

  assign base_s  = $signed({{(DSUM_W-SPEED_W){1'b0}}, base_speed});
  assign drift_s = base_s + DSUM_W'(DRIFT);

  always_comb begin
    raw_l = '0;
    raw_r = '0;
    if (trk) begin
      raw_l = trk_right ? drv_n : drv_p;
      raw_r = trk_right ? drv_p : drv_n;
    end else if (lost_drift) begin
      raw_l = drift_right ? drift_s : (base_s - DSUM_W'(DRIFT));
      raw_r = drift_right ? (base_s - DSUM_W'(DRIFT)) : drift_s;
    end
  end

  assign lim = $signed({{(DSUM_W-PWM_W){1'b0}}, cfg.max_pwm});

  assign res.drive_valid = trk | lost_drift;
  assign res.tracking    = trk;
  assign res.drive_left  = res.drive_valid ? clamp_drv(raw_l, lim) : '0;
  assign res.drive_right = res.drive_valid ? clamp_drv(raw_r, lim) : '0;

  assign err_upd.load  = trk | clr;
  assign err_upd.value = trk ? err : '0;

endmodule

`default_nettype wire
